/* rtl/core/wsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

	localparam logic [1:0] PH_RIFF  = 2'd0;
	localparam logic [1:0] PH_CHUNK = 2'd1;
	localparam logic [1:0] PH_BODY  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_HDR   = 2'd1;
	localparam logic [1:0] ST_BAD_DATA  = 2'd2;
	localparam logic [1:0] ST_BAD_BITS  = 2'd3;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_DATA  = 32'h6461_7461;

	localparam logic [31:0] POS_RIFF_END  = 32'd4;
	localparam logic [31:0] POS_WAVE      = 32'd8;
	localparam logic [31:0] POS_HDR_END   = 32'd11;
	localparam logic [31:0] POS_CHAN_LO   = 32'd22;
	localparam logic [31:0] POS_CHAN_HI   = 32'd23;
	localparam logic [29:0] POS_RATE_WORD = 30'd6;
	localparam logic [31:0] POS_BITS_LO   = 32'd34;
	localparam logic [31:0] POS_BITS_HI   = 32'd35;
	localparam logic [31:0] POS_MIN_LAST  = 32'd43;

	localparam logic [15:0] PCM_BITS    = 16'd16;
	localparam logic [15:0] STEREO      = 16'd2;
	localparam logic [15:0] GAIN_UNITY  = 16'd4096;

	// Byte idx of a four-character tag, first character in the top byte.
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = tag[31:24];
			2'd1: b = tag[23:16];
			2'd2: b = tag[15:8];
			default: b = tag[7:0];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/wav_stream_parser_with_gain.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted word goes into the input register and from there, when the result side
// is free, into the result register; the parse state is updated at that same edge.
// Throughput: one word per cycle while the result side is not stalled; a held result
// stops the input register and, behind it, the input channel.
// Reset (arst_n low) clears the parse state and the pipeline and sets the gain to unity.
module wav_stream_parser_with_gain (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  wav_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             sample_valid,
	output logic signed [15:0] sample,
	output logic             sample_channel,
	output logic             done_res,
	output logic [1:0]       status,
	output logic [31:0]      rate_hz,
	output logic [15:0]      channel_count
);
	import wsp_pkg::*;

	logic [15:0] gain_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [31:0] pos_q, pos_d;
	logic        hdr_ok_q, hdr_ok_d;
	logic [15:0] chans_q, chans_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [1:0]  phase_q, phase_d;
	logic [2:0]  chi_q, chi_d;
	logic [31:0] id_q, id_d;
	logic [31:0] size_q, size_d;
	logic [31:0] remain_q, remain_d;
	logic [8:0]  hold_q, hold_d;
	logic        toggle_q, toggle_d;
	logic        seen_q, seen_d;

	logic        emit;
	logic        chan;
	logic [1:0]  stat;
	logic [15:0] raw;
	logic signed [32:0] prod;
	logic signed [32:0] biased;
	logic signed [20:0] quot;
	logic signed [15:0] scaled;

	logic        out_free;
	logic        advance;

	logic        out_valid_q;
	logic        sample_valid_q;
	logic signed [15:0] sample_q;
	logic        chan_q;
	logic        done_q;
	logic [1:0]  status_q;
	logic [31:0] rate_out_q;
	logic [15:0] chans_out_q;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_UNITY;
		end else if (cfg_wr_en) begin
			gain_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= wav_byte;
			last_s1 <= last_byte;
		end
	end

	assign raw    = {byte_s1, hold_q[7:0]};
	assign prod   = $signed(raw) * $signed({1'b0, gain_q});
	assign biased = prod + (prod[32] ? 33'sd4095 : 33'sd0);
	assign quot   = biased[32:12];

	always_comb begin
		if (quot > 21'sd32767) begin
			scaled = 16'sh7FFF;
		end else if (quot < -21'sd32768) begin
			scaled = 16'sh8000;
		end else begin
			scaled = quot[15:0];
		end
	end

	always_comb begin
		pos_d    = pos_q;
		hdr_ok_d = hdr_ok_q;
		chans_d  = chans_q;
		rate_d   = rate_q;
		bits_d   = bits_q;
		phase_d  = phase_q;
		chi_d    = chi_q;
		id_d     = id_q;
		size_d   = size_q;
		remain_d = remain_q;
		hold_d   = hold_q;
		toggle_d = toggle_q;
		seen_d   = seen_q;
		emit     = 1'b0;
		chan     = 1'b0;
		stat     = ST_OK;

		if (pos_q == POS_CHAN_LO) chans_d[7:0] = byte_s1;
		if (pos_q == POS_CHAN_HI) chans_d[15:8] = byte_s1;
		if (pos_q[31:2] == POS_RATE_WORD) begin
			case (pos_q[1:0])
				2'd0: rate_d[7:0] = byte_s1;
				2'd1: rate_d[15:8] = byte_s1;
				2'd2: rate_d[23:16] = byte_s1;
				default: rate_d[31:24] = byte_s1;
			endcase
		end
		if (pos_q == POS_BITS_LO) bits_d[7:0] = byte_s1;
		if (pos_q == POS_BITS_HI) bits_d[15:8] = byte_s1;

		case (phase_q)
			PH_RIFF: begin
				if (pos_q < POS_RIFF_END) begin
					if (byte_s1 != tag_byte(TAG_RIFF, pos_q[1:0])) hdr_ok_d = 1'b0;
				end else if (pos_q >= POS_WAVE && pos_q <= POS_HDR_END) begin
					if (byte_s1 != tag_byte(TAG_WAVE, pos_q[1:0])) hdr_ok_d = 1'b0;
				end
				if (pos_q >= POS_HDR_END) begin
					phase_d = PH_CHUNK;
					chi_d   = 3'd0;
				end
			end
			PH_CHUNK: begin
				if (!chi_q[2]) begin
					id_d = {id_q[23:0], byte_s1};
				end else begin
					size_d = {byte_s1, size_q[31:8]};
				end
				chi_d = chi_q + 3'd1;
				if (chi_q == 3'd7) begin
					remain_d = size_d;
					if (id_q == ID_DATA) begin
						if (size_d == 32'd0) begin
							phase_d = PH_DONE;
						end else begin
							phase_d  = PH_BODY;
							seen_d   = 1'b1;
							hold_d   = 9'd0;
							toggle_d = 1'b0;
						end
					end else if (size_d != 32'd0) begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (remain_q != 32'd0) remain_d = remain_q - 32'd1;
				if (seen_q) begin
					if (!hold_q[8]) begin
						hold_d = {1'b1, byte_s1};
					end else begin
						hold_d = 9'd0;
						if (hdr_ok_q && bits_d == PCM_BITS) begin
							emit = 1'b1;
							if (chans_d == STEREO) begin
								chan     = toggle_q;
								toggle_d = !toggle_q;
							end
						end
					end
					if (remain_d == 32'd0) phase_d = PH_DONE;
				end else if (remain_d == 32'd0) begin
					phase_d = PH_CHUNK;
				end
			end
			default: begin
			end
		endcase

		if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;

		if (last_s1) begin
			if (!hdr_ok_d || pos_q < POS_MIN_LAST) begin
				stat = ST_BAD_HDR;
			end else if (!seen_d || phase_d != PH_DONE) begin
				stat = ST_BAD_DATA;
			end else if (bits_d != PCM_BITS) begin
				stat = ST_BAD_BITS;
			end else begin
				stat = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 32'd0;
			hdr_ok_q <= 1'b1;
			chans_q  <= 16'd0;
			rate_q   <= 32'd0;
			bits_q   <= 16'd0;
			phase_q  <= PH_RIFF;
			chi_q    <= 3'd0;
			id_q     <= 32'd0;
			size_q   <= 32'd0;
			remain_q <= 32'd0;
			hold_q   <= 9'd0;
			toggle_q <= 1'b0;
			seen_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q    <= 32'd0;
				hdr_ok_q <= 1'b1;
				chans_q  <= 16'd0;
				rate_q   <= 32'd0;
				bits_q   <= 16'd0;
				phase_q  <= PH_RIFF;
				chi_q    <= 3'd0;
				id_q     <= 32'd0;
				size_q   <= 32'd0;
				remain_q <= 32'd0;
				hold_q   <= 9'd0;
				toggle_q <= 1'b0;
				seen_q   <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				hdr_ok_q <= hdr_ok_d;
				chans_q  <= chans_d;
				rate_q   <= rate_d;
				bits_q   <= bits_d;
				phase_q  <= phase_d;
				chi_q    <= chi_d;
				id_q     <= id_d;
				size_q   <= size_d;
				remain_q <= remain_d;
				hold_q   <= hold_d;
				toggle_q <= toggle_d;
				seen_q   <= seen_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit || last_s1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_valid_q <= emit;
			sample_q       <= emit ? scaled : 16'sd0;
			chan_q         <= chan;
			done_q         <= last_s1;
			status_q       <= stat;
			rate_out_q     <= rate_d;
			chans_out_q    <= chans_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_valid   = sample_valid_q;
	assign sample         = sample_q;
	assign sample_channel = chan_q;
	assign done_res       = done_q;
	assign status         = status_q;
	assign rate_hz        = rate_out_q;
	assign channel_count  = chans_out_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (sample_valid_q || done_q))
		else $error("result word carries neither a sample nor a status");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sample_valid_q) |-> (sample_q == 16'sd0 && !chan_q))
		else $error("sample fields not cleared on a status-only word");

	a_body_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (remain_q != 32'd0))
		else $error("chunk body phase with no bytes remaining");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import wsp_pkg::*;

	localparam logic [31:0] TAG_FMT = 32'h666d_7420;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wav_word_t;

	typedef struct packed {
		logic        smp_valid;
		logic [15:0] smp;
		logic        chan;
		logic        done;
		logic [1:0]  stat;
		logic [31:0] rate;
		logic [15:0] chans;
	} parser_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic [7:0]  wav_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire         sample_valid;
	wire  [15:0] sample;
	wire         sample_channel;
	wire         done_res;
	wire  [1:0]  status;
	wire  [31:0] rate_hz;
	wire  [15:0] channel_count;

	wav_word_t   file_bytes_q[$];
	parser_out_t parser_out_q[$];
	logic [7:0]  file_img[$];
	int          errors = 0;

	// Predictor state.
	logic [15:0] gain_q = GAIN_UNITY;
	logic [31:0] pos_cnt;
	logic        hdr_good;
	logic [15:0] chan_cnt;
	logic [31:0] rate_val;
	logic [15:0] bits_val;
	logic [1:0]  phase;
	logic [2:0]  hdr_idx;
	logic [31:0] id_acc;
	logic [31:0] size_acc;
	logic [31:0] remain;
	logic [8:0]  lo_hold;
	logic        chan_flip;
	logic        data_found;

	wav_stream_parser_with_gain DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wav_byte(wav_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_valid(sample_valid),
		.sample(sample),
		.sample_channel(sample_channel),
		.done_res(done_res),
		.status(status),
		.rate_hz(rate_hz),
		.channel_count(channel_count)
	);

	always #6 clk = ~clk;

	task automatic clear_parse();
		pos_cnt = '0;
		hdr_good = 1'b1;
		chan_cnt = '0;
		rate_val = '0;
		bits_val = '0;
		phase = PH_RIFF;
		hdr_idx = '0;
		id_acc = '0;
		size_acc = '0;
		remain = '0;
		lo_hold = '0;
		chan_flip = 1'b0;
		data_found = 1'b0;
	endtask

	function automatic logic [15:0] apply_gain(input logic [15:0] raw);
		longint s;
		longint prod;
		s = $signed(raw);
		prod = (s * longint'(gain_q)) / 4096;
		if (prod > 32767)
			prod = 32767;
		if (prod < -32768)
			prod = -32768;
		return prod[15:0];
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic lb);
		logic [31:0] p;
		logic        emit;
		logic [15:0] smp;
		logic        ch;
		logic [1:0]  st;
		int          off;
		p = pos_cnt;
		emit = 1'b0;
		smp = '0;
		ch = 1'b0;
		st = ST_OK;
		if (p == POS_CHAN_LO)
			chan_cnt[7:0] = b;
		if (p == POS_CHAN_HI)
			chan_cnt[15:8] = b;
		if (p >= 24 && p <= 27) begin
			off = (p - 24) * 8;
			rate_val[off +: 8] = b;
		end
		if (p == POS_BITS_LO)
			bits_val[7:0] = b;
		if (p == POS_BITS_HI)
			bits_val[15:8] = b;
		case (phase)
			PH_RIFF: begin
				if (p < 4) begin
					if (b != TAG_RIFF[31 - 8 * p[1:0] -: 8])
						hdr_good = 1'b0;
				end else if (p >= 8 && p < 12) begin
					if (b != TAG_WAVE[31 - 8 * p[1:0] -: 8])
						hdr_good = 1'b0;
				end
				if (p >= POS_HDR_END) begin
					phase = PH_CHUNK;
					hdr_idx = '0;
				end
			end
			PH_CHUNK: begin
				if (hdr_idx < 4)
					id_acc = {id_acc[23:0], b};
				else
					size_acc = {b, size_acc[31:8]};
				hdr_idx = hdr_idx + 3'd1;
				if (hdr_idx == 3'd0) begin
					remain = size_acc;
					if (id_acc == ID_DATA) begin
						if (size_acc == 0) begin
							phase = PH_DONE;
						end else begin
							phase = PH_BODY;
							data_found = 1'b1;
							lo_hold = '0;
							chan_flip = 1'b0;
						end
					end else if (size_acc != 0) begin
						phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (remain > 0)
					remain = remain - 1;
				if (data_found) begin
					if (!lo_hold[8]) begin
						lo_hold = {1'b1, b};
					end else begin
						if (hdr_good && bits_val == PCM_BITS) begin
							emit = 1'b1;
							smp = apply_gain({b, lo_hold[7:0]});
							if (chan_cnt == STEREO) begin
								ch = chan_flip;
								chan_flip = ~chan_flip;
							end
						end
						lo_hold = '0;
					end
					if (remain == 0)
						phase = PH_DONE;
				end else if (remain == 0) begin
					phase = PH_CHUNK;
				end
			end
			default: ;
		endcase
		if (pos_cnt != '1)
			pos_cnt = pos_cnt + 1;
		if (lb) begin
			if (!hdr_good || p < POS_MIN_LAST)
				st = ST_BAD_HDR;
			else if (!data_found || phase != PH_DONE)
				st = ST_BAD_DATA;
			else if (bits_val != PCM_BITS)
				st = ST_BAD_BITS;
		end
		if (emit || lb)
			parser_out_q.push_back({emit, smp, ch, lb, st, rate_val, chan_cnt});
		if (lb)
			clear_parse();
	endtask

	always @(posedge clk) begin : driver
		wav_word_t w;
		int gap_left;
		int burst_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			wav_byte <= '0;
			last_byte <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(wav_byte, last_byte);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (file_bytes_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					w = file_bytes_q.pop_front();
					in_valid <= 1'b1;
					wav_byte <= w.data;
					last_byte <= w.last;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	function automatic string fmt_res(input parser_out_t r);
		return $sformatf("sv=%0d smp=%0d ch=%0d done=%0d st=%0d rate=%h chans=%0d",
			r.smp_valid, $signed(r.smp), r.chan, r.done, r.stat, r.rate, r.chans);
	endfunction

	always @(posedge clk) begin : monitor
		parser_out_t got;
		parser_out_t want;
		logic [15:0] stall_pat;
		int pat_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_pat = '0;
			pat_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {sample_valid, sample, sample_channel, done_res, status,
					rate_hz, channel_count};
				if (parser_out_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: %s", fmt_res(got));
				end else begin
					want = parser_out_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %s, got %s",
								fmt_res(want), fmt_res(got));
					end
				end
			end
			if (pat_left == 0) begin
				pat_left = $urandom_range(16, 200);
				case ($urandom_range(0, 3))
					0: stall_pat = '0;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom & $urandom);
					default: stall_pat = 16'($urandom | $urandom);
				endcase
			end
			pat_left--;
			out_stall <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
		end
	end

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_img.push_back(v[8 * i +: 8]);
	endtask

	task automatic put_tag(input logic [31:0] tag);
		for (int i = 0; i < 4; i++)
			file_img.push_back(tag[31 - 8 * i -: 8]);
	endtask

	function automatic logic [7:0] body_byte(input bit fixed, input int i);
		logic [7:0] pick;
		if (fixed) begin
			case (i % 10)
				0: pick = 8'hFF;
				1: pick = 8'h7F;
				2: pick = 8'h00;
				3: pick = 8'h80;
				4: pick = 8'hFF;
				5: pick = 8'hFF;
				6: pick = 8'h01;
				default: pick = 8'h00;
			endcase
		end else begin
			case ($urandom_range(0, 5))
				0: pick = 8'h00;
				1: pick = 8'hFF;
				2: pick = 8'h80;
				3: pick = 8'h7F;
				default: pick = 8'($urandom);
			endcase
		end
		return pick;
	endfunction

	task automatic add_file(input bit riff_ok, input bit wave_ok, input logic [15:0] chans,
			input logic [15:0] bits, input int n_extra, input bit has_data,
			input logic [31:0] data_len, input bit fixed, input bit cut, input int tail);
		logic [31:0] id;
		int sz;
		int n;
		file_img.delete();
		put_tag(TAG_RIFF);
		put_le($urandom, 4);
		put_tag(TAG_WAVE);
		if (!riff_ok)
			file_img[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
		if (!wave_ok)
			file_img[$urandom_range(8, 11)] ^= 8'h01 << $urandom_range(0, 7);
		put_tag(TAG_FMT);
		put_le(32'd16, 4);
		put_le($urandom, 2);
		put_le({16'd0, chans}, 2);
		put_le($urandom, 4);
		put_le($urandom, 4);
		put_le($urandom, 2);
		put_le({16'd0, bits}, 2);
		for (int e = 0; e < n_extra; e++) begin
			id = $urandom;
			if (id == ID_DATA)
				id ^= 32'd1;
			sz = $urandom_range(0, 12);
			put_tag(id);
			put_le(sz, 4);
			repeat (sz) put_le($urandom, 1);
		end
		if (has_data) begin
			put_tag(ID_DATA);
			put_le(data_len, 4);
			for (int i = 0; i < data_len; i++)
				file_img.push_back(body_byte(fixed, i));
		end
		repeat (tail) put_le($urandom, 1);
		n = cut ? $urandom_range(1, file_img.size() - 1) : file_img.size();
		for (int i = 0; i < n; i++)
			file_bytes_q.push_back({file_img[i], i == n - 1});
	endtask

	task automatic add_random_file();
		logic [15:0] chans;
		logic [15:0] bits;
		logic [31:0] dlen;
		case ($urandom_range(0, 3))
			0: chans = 16'd1;
			3: chans = 16'($urandom);
			default: chans = STEREO;
		endcase
		bits = PCM_BITS;
		if ($urandom_range(0, 7) == 0)
			bits = ($urandom_range(0, 1) == 0) ? 16'd8 : 16'($urandom);
		case ($urandom_range(0, 11))
			0: dlen = 0;
			1, 2: dlen = 2 * $urandom_range(0, 16) + 1;
			3: dlen = $urandom_range(60, 120);
			default: dlen = 2 * $urandom_range(1, 20);
		endcase
		add_file($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0, chans, bits,
			($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0,
			$urandom_range(0, 11) != 0, dlen, 1'b0, $urandom_range(0, 7) == 0,
			($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
	endtask

	task automatic add_noise();
		int n;
		n = $urandom_range(1, 50);
		for (int i = 0; i < n; i++)
			file_bytes_q.push_back({8'($urandom), i == n - 1});
	endtask

	task automatic drain();
		while (file_bytes_q.size() != 0 || in_valid)
			@(negedge clk);
		while (parser_out_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_gain(input logic [15:0] g);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gain_q = g;
	endtask

	initial begin : stimulus
		logic [15:0] gains[7];
		int count;
		int queued;
		clear_parse();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short files, then whole files that cover each status and the sample extremes.
		file_bytes_q.push_back({8'h52, 1'b1});
		file_bytes_q.push_back({8'h52, 1'b0});
		file_bytes_q.push_back({8'h49, 1'b0});
		file_bytes_q.push_back({8'h46, 1'b1});
		add_file(1, 1, 16'd1, PCM_BITS, 0, 1, 10, 1, 0, 0);
		add_file(1, 1, STEREO, PCM_BITS, 1, 1, 7, 1, 0, 2);
		add_file(1, 1, STEREO, PCM_BITS, 0, 1, 0, 0, 0, 0);
		add_file(1, 1, 16'd1, 16'd8, 0, 1, 4, 1, 0, 0);
		add_file(1, 1, 16'd1, PCM_BITS, 0, 0, 0, 0, 0, 0);
		add_file(1, 0, 16'd1, PCM_BITS, 0, 1, 4, 1, 0, 0);
		add_file(1, 1, 16'd1, PCM_BITS, 0, 1, 20, 1, 1, 0);
		drain();

		gains[0] = GAIN_UNITY;
		gains[1] = 16'hFFFF;
		gains[2] = 16'd0;
		gains[3] = 16'd4095;
		gains[4] = 16'd1;
		gains[5] = 16'($urandom);
		gains[6] = 16'd8192;
		for (int g = 0; g < 7; g++) begin
			set_gain(gains[g]);
			if (g == 1)
				add_file(1, 1, STEREO, PCM_BITS, 0, 1, 10, 1, 0, 0);
			count = 0;
			while (count < 60) begin
				queued = file_bytes_q.size();
				if ($urandom_range(0, 9) == 0) begin
					add_noise();
				end else begin
					add_random_file();
				end
				count = count + file_bytes_q.size() - queued;
				while (file_bytes_q.size() > 64)
					@(negedge clk);
			end
			drain();
		end

		if (errors == 0 && parser_out_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
